[rtl/core/ffg_pkg.sv]
// shared constants, types and the cell update rule of the forest fire grid
package ffg_pkg;

  localparam int GRID_WIDTH  = 128;
  localparam int GRID_HEIGHT = 128;
  localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int LB_AW   = $clog2(GRID_WIDTH);
  localparam int ROWC_W  = $clog2(GRID_HEIGHT + 1);
  localparam int COL_W   = 7;
  localparam int ROW_W   = 7;
  localparam int CELL_W  = 2;
  localparam int COUNT_W = 15;

  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [1:0]         op_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_READ  = 2'd1;
  localparam op_t OP_STEP  = 2'd2;

  localparam cell_t CELL_EMPTY   = 2'd0;
  localparam cell_t CELL_TREE    = 2'd1;
  localparam cell_t CELL_BURNING = 2'd2;
  localparam cell_t CELL_ASH     = 2'd3;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_STEP,
    S_DONE
  } state_t;

  function automatic cell_t cell_next(input cell_t center, input cell_t left,
                                      input cell_t right, input cell_t up,
                                      input cell_t down, input logic border);
    cell_t res;
    res = center;
    if (!border) begin
      if (center == CELL_TREE) begin
        if (left == CELL_BURNING || right == CELL_BURNING ||
            up == CELL_BURNING || down == CELL_BURNING) begin
          res = CELL_BURNING;
        end
      end else if (center == CELL_BURNING) begin
        res = CELL_ASH;
      end
    end
    return res;
  endfunction

endpackage

[rtl/core/ffg_ifs.sv]
// request and result channels of the forest fire grid
interface ffg_req_if import ffg_pkg::*; ();
  logic               valid;
  logic               ready;
  op_t                operation;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  cell_t              cell_in;

  modport source (output valid, operation, col, row, cell_in, input ready);
  modport sink   (input valid, operation, col, row, cell_in, output ready);
endinterface

interface ffg_res_if import ffg_pkg::*; ();
  logic   valid;
  logic   ready;
  cell_t  cell_out;
  count_t burning_count;
  count_t changed_count;

  modport source (output valid, cell_out, burning_count, changed_count, input ready);
  modport sink   (input valid, cell_out, burning_count, changed_count, output ready);
endinterface

[rtl/core/forest_fire_grid_step_unit.sv]
// forest fire grid: cell write/read and one-generation step over a ram grid
//
//   channel | dir | payload
//   req     | in  | operation, col, row, cell_in
//   res     | out | cell_out, burning_count, changed_count
//
// a generation step does one grid ram read and one write per cycle, rows streamed
// in raster order with a two-row line buffer ram in front; after reset a clearing
// pass empties the grid, req.ready stays low meanwhile
// a new request is taken while the previous result still waits in the output
// register; res stalls hold that register and keep the next request in S_DONE
module forest_fire_grid_step_unit import ffg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  ffg_req_if.sink  req,
  ffg_res_if.source res
);

  state_t state, state_next;

  // latched request
  op_t               req_op;
  logic [ADDR_W-1:0] req_addr;
  cell_t             req_cell;
  logic              req_in;

  // sweep/write address, fetch address and fetch position
  logic [ADDR_W-1:0] wa;
  logic [ADDR_W-1:0] fa;
  logic [ROWC_W-1:0] rf;
  logic [LB_AW-1:0]  cf;
  logic              fetch_on;

  // data stage
  logic              vd;
  logic [ROWC_W-1:0] rd;
  logic [LB_AW-1:0]  cd;
  cell_t             w1_up, w1_cur, w1_dn, w2_cur;
  count_t            burn_cnt, chg_cnt;

  // output register
  logic   out_valid;
  cell_t  out_cell;
  count_t out_burn, out_chg;

  // ram ports
  logic              grid_we, grid_re;
  logic [ADDR_W-1:0] grid_waddr, grid_raddr;
  cell_t             grid_wdata, grid_rdata;
  logic              lb_we, lb_re;
  logic [3:0]        lb_rdata;

  logic  in_fire, out_free;
  logic  border, cell_valid, last_cell, fetch_last;
  cell_t lb_a, lb_b, nxt;

  assign in_fire  = req.valid && req.ready;
  assign out_free = !out_valid || res.ready;
  assign req.ready = (state == S_IDLE);

  assign res.valid         = out_valid;
  assign res.cell_out      = out_cell;
  assign res.burning_count = out_burn;
  assign res.changed_count = out_chg;

  ffg_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .re    (grid_re),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  // line buffer: per column the two rows above the one being fetched
  ffg_ram #(.WIDTH(2 * CELL_W), .DEPTH(GRID_WIDTH)) u_line (
    .clk   (clk),
    .we    (lb_we),
    .waddr (cd),
    .wdata ({lb_b, grid_rdata}),
    .re    (lb_re),
    .raddr (cf),
    .rdata (lb_rdata)
  );

  // data stage: center is the column before the one just fetched, one row up
  // (at column 0 it is the last column two rows up)
  always_comb begin
    lb_a       = lb_rdata[3:2];
    lb_b       = lb_rdata[1:0];
    border     = (cd <= LB_AW'(1)) || (rd == ROWC_W'(1)) ||
                 (rd == ROWC_W'(GRID_HEIGHT));
    cell_valid = vd && ((rd >= ROWC_W'(2)) || (rd == ROWC_W'(1) && cd != '0));
    last_cell  = vd && (rd == ROWC_W'(GRID_HEIGHT + 1)) && (cd == '0);
    fetch_last = (rf == ROWC_W'(GRID_HEIGHT + 1)) && (cf == '0);
    nxt        = cell_next(w1_cur, w2_cur, lb_b, w1_up, w1_dn, border);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (wa == ADDR_W'(CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (req.operation)
            OP_WRITE: state_next = S_ACCESS;
            OP_READ:  state_next = S_ACCESS;
            OP_STEP:  state_next = S_STEP;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_ACCESS: state_next = S_DONE;
      S_STEP: begin
        if (last_cell) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    grid_we    = 1'b0;
    grid_waddr = wa;
    grid_wdata = nxt;
    grid_re    = 1'b0;
    grid_raddr = fa;
    lb_we      = 1'b0;
    lb_re      = 1'b0;
    unique case (state)
      S_CLEAR: begin
        grid_we    = 1'b1;
        grid_wdata = CELL_EMPTY;
      end
      S_ACCESS: begin
        grid_waddr = req_addr;
        grid_wdata = req_cell;
        grid_raddr = req_addr;
        grid_we    = req_in && (req_op == OP_WRITE);
        grid_re    = req_in && (req_op == OP_READ);
      end
      S_STEP: begin
        grid_re = fetch_on && (rf < ROWC_W'(GRID_HEIGHT));
        lb_re   = fetch_on;
        grid_we = cell_valid;
        lb_we   = vd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      wa        <= '0;
      fetch_on  <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (state == S_CLEAR) begin
        wa <= wa + ADDR_W'(1);
      end

      if (in_fire) begin
        wa       <= '0;
        fa       <= '0;
        rf       <= '0;
        cf       <= '0;
        fetch_on <= (req.operation == OP_STEP);
        vd       <= 1'b0;
        burn_cnt <= '0;
        chg_cnt  <= '0;
      end

      if (state == S_STEP) begin
        if (fetch_on) begin
          if (grid_re) begin
            fa <= fa + ADDR_W'(1);
          end
          if (cf == LB_AW'(GRID_WIDTH - 1)) begin
            cf <= '0;
            rf <= rf + ROWC_W'(1);
          end else begin
            cf <= cf + LB_AW'(1);
          end
          if (fetch_last) begin
            fetch_on <= 1'b0;
          end
        end
        vd <= fetch_on;
        rd <= rf;
        cd <= cf;
        if (vd) begin
          w2_cur <= w1_cur;
          w1_up  <= lb_a;
          w1_cur <= lb_b;
          w1_dn  <= grid_rdata;
        end
        if (cell_valid) begin
          wa <= wa + ADDR_W'(1);
          if (nxt == CELL_BURNING && burn_cnt != COUNT_MAX) begin
            burn_cnt <= burn_cnt + COUNT_W'(1);
          end
          if (nxt != w1_cur && chg_cnt != COUNT_MAX) begin
            chg_cnt <= chg_cnt + COUNT_W'(1);
          end
        end
      end

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op   <= req.operation;
      req_cell <= req.cell_in;
      req_in   <= (32'(req.col) < GRID_WIDTH) && (32'(req.row) < GRID_HEIGHT);
      req_addr <= ADDR_W'(ADDR_W'(req.row) * ADDR_W'(GRID_WIDTH)) + ADDR_W'(req.col);
    end
    if (state == S_DONE && out_free) begin
      out_cell <= (req_op == OP_READ && req_in) ? grid_rdata : CELL_EMPTY;
      out_burn <= (req_op == OP_STEP) ? burn_cnt : '0;
      out_chg  <= (req_op == OP_STEP) ? chg_cnt : '0;
    end
  end

endmodule

[rtl/core/ffg_ram.sv]
// generic simple dual port ram, one write port, one registered read port
module ffg_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
